[src/tcfe_pkg.sv]
// tcfe_pkg: codes, frame layout table and bcd digit helpers for the time code encoder
// no dependencies; imported by time_code_frame_encoder
`timescale 1ns / 1ps

package tcfe_pkg;

    // register indexes
    localparam logic REG_MAX_FRAMES = 1'b0;

    // input kinds carried in tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // symbol codes
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_MARK = 2'd2;

    // reduced-power durations in ms
    localparam logic [9:0] MS_ZERO = 10'd200;
    localparam logic [9:0] MS_ONE  = 10'd500;
    localparam logic [9:0] MS_MARK = 10'd800;

    // frame and clock limits
    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [6:0] MIN_PER_HR = 7'd60;
    localparam logic [5:0] HR_PER_DAY = 6'd24;

    // bit sources within the frame
    localparam logic [3:0] SRC_ZERO  = 4'd0;
    localparam logic [3:0] SRC_ONE   = 4'd1;
    localparam logic [3:0] SRC_MARK  = 4'd2;
    localparam logic [3:0] SRC_MIN_T = 4'd3;
    localparam logic [3:0] SRC_MIN_O = 4'd4;
    localparam logic [3:0] SRC_HR_T  = 4'd5;
    localparam logic [3:0] SRC_HR_O  = 4'd6;
    localparam logic [3:0] SRC_DAY_H = 4'd7;
    localparam logic [3:0] SRC_DAY_T = 4'd8;
    localparam logic [3:0] SRC_DAY_O = 4'd9;
    localparam logic [3:0] SRC_YR_T  = 4'd10;
    localparam logic [3:0] SRC_YR_O  = 4'd11;
    localparam logic [3:0] SRC_LEAP  = 4'd12;
    localparam logic [3:0] SRC_DST_N = 4'd13;
    localparam logic [3:0] SRC_DST_B = 4'd14;

    typedef struct packed {
        logic [3:0] src;
        logic [1:0] pos;
    } frame_entry_t;

    // frame layout: what each second of the minute carries
    function automatic frame_entry_t frame_entry(input logic [5:0] sec);
        frame_entry_t e;
        e.src = SRC_ZERO;
        e.pos = 2'd0;
        case (sec)
            6'd0, 6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: e.src = SRC_MARK;
            6'd1:  begin e.src = SRC_MIN_T; e.pos = 2'd2; end
            6'd2:  begin e.src = SRC_MIN_T; e.pos = 2'd1; end
            6'd3:  begin e.src = SRC_MIN_T; e.pos = 2'd0; end
            6'd5:  begin e.src = SRC_MIN_O; e.pos = 2'd3; end
            6'd6:  begin e.src = SRC_MIN_O; e.pos = 2'd2; end
            6'd7:  begin e.src = SRC_MIN_O; e.pos = 2'd1; end
            6'd8:  begin e.src = SRC_MIN_O; e.pos = 2'd0; end
            6'd12: begin e.src = SRC_HR_T;  e.pos = 2'd1; end
            6'd13: begin e.src = SRC_HR_T;  e.pos = 2'd0; end
            6'd15: begin e.src = SRC_HR_O;  e.pos = 2'd3; end
            6'd16: begin e.src = SRC_HR_O;  e.pos = 2'd2; end
            6'd17: begin e.src = SRC_HR_O;  e.pos = 2'd1; end
            6'd18: begin e.src = SRC_HR_O;  e.pos = 2'd0; end
            6'd22: begin e.src = SRC_DAY_H; e.pos = 2'd1; end
            6'd23: begin e.src = SRC_DAY_H; e.pos = 2'd0; end
            6'd25: begin e.src = SRC_DAY_T; e.pos = 2'd3; end
            6'd26: begin e.src = SRC_DAY_T; e.pos = 2'd2; end
            6'd27: begin e.src = SRC_DAY_T; e.pos = 2'd1; end
            6'd28: begin e.src = SRC_DAY_T; e.pos = 2'd0; end
            6'd30: begin e.src = SRC_DAY_O; e.pos = 2'd3; end
            6'd31: begin e.src = SRC_DAY_O; e.pos = 2'd2; end
            6'd32: begin e.src = SRC_DAY_O; e.pos = 2'd1; end
            6'd33: begin e.src = SRC_DAY_O; e.pos = 2'd0; end
            6'd36, 6'd38: e.src = SRC_ONE;
            6'd45: begin e.src = SRC_YR_T;  e.pos = 2'd3; end
            6'd46: begin e.src = SRC_YR_T;  e.pos = 2'd2; end
            6'd47: begin e.src = SRC_YR_T;  e.pos = 2'd1; end
            6'd48: begin e.src = SRC_YR_T;  e.pos = 2'd0; end
            6'd50: begin e.src = SRC_YR_O;  e.pos = 2'd3; end
            6'd51: begin e.src = SRC_YR_O;  e.pos = 2'd2; end
            6'd52: begin e.src = SRC_YR_O;  e.pos = 2'd1; end
            6'd53: begin e.src = SRC_YR_O;  e.pos = 2'd0; end
            6'd55: e.src = SRC_LEAP;
            6'd57: e.src = SRC_DST_N;
            6'd58: e.src = SRC_DST_B;
            default: e.src = SRC_ZERO;
        endcase
        return e;
    endfunction

    // divide by ten through a reciprocal, exact for values below 1029
    function automatic logic [5:0] div10(input logic [8:0] v);
        logic [17:0] p;
        p = {9'd0, v} * 18'd205;
        return p[16:11];
    endfunction

    // low decimal digit
    function automatic logic [3:0] mod10(input logic [8:0] v);
        logic [5:0] q;
        logic [8:0] r;
        q = div10(v);
        r = v - ({3'd0, q} * 9'd10);
        return r[3:0];
    endfunction

    // divide by one hundred through a reciprocal, exact for nine-bit values
    function automatic logic [2:0] div100(input logic [8:0] v);
        logic [17:0] p;
        p = {9'd0, v} * 18'd41;
        return p[14:12];
    endfunction

endpackage

[src/time_code_frame_encoder.sv]
// time_code_frame_encoder: 60-second time code frame generator with apb config port
// depends on tcfe_pkg for symbol codes, frame layout and bcd helpers
`timescale 1ns / 1ps

// channel  | direction | accepted when         | carries
// s_       | in        | s_tvalid & s_tready   | load time (tuser 0) or tick (tuser 1)
// m_       | out       | m_tvalid & m_tready   | symbol, reduced ms, tlast on final symbol
// apb      | in        | psel&penable&pwrite   | max_frames at byte address 0
//
// one beat per cycle unless stalled: a tick is encoded from the clock registers in the
// cycle it is accepted and lands in the output register on that edge; the next beat follows at once
// s_tready drops only while the output register is full and m_tready is low
// loads and ticks while idle give no output beat
// aresetn is synchronous and active low; it resets the clock state (day to 1, the rest to 0) and max_frames to 10

module time_code_frame_encoder
    import tcfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // year_in_century[6:0], day_number[15:7], hour_of_day[20:16], minute_of_hour[26:21],
    // second_of_minute[32:27], leap_year_flag[33], dst_now[34], dst_day_before[35], zero
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,    // action: 0 load, 1 tick
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // symbol[1:0], reduced_ms[11:2], zero
    output logic        m_tlast,    // last_symbol
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // clock and broadcast state
    logic       active_reg, active_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [8:0] day_reg, day_next;
    logic [6:0] year_reg, year_next;
    logic [2:0] flag_reg, flag_next;
    logic [7:0] frames_reg, frames_next;
    logic [7:0] max_frames_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic         in_beat;
    logic         tick_emit;
    frame_entry_t entry;
    logic [3:0]   digit;
    logic [1:0]   sym;
    logic [9:0]   ms;
    logic         last;
    logic [6:0]   min_inc;
    logic [5:0]   hour_inc;
    logic [7:0]   frames_inc;
    logic [5:0]   day_tens;
    logic [5:0]   min_tens;
    logic [5:0]   hour_tens;
    logic [5:0]   year_tens;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign tick_emit = in_beat && (s_tuser == ACT_TICK) && active_reg;

    // apb register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_FRAMES) ? {24'd0, max_frames_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frames_reg <= 8'd10;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_FRAMES)) begin
            max_frames_reg <= pwdata[7:0];
        end
    end

    // bcd digit for the current second
    assign entry     = frame_entry(sec_reg);
    assign day_tens  = div10(day_reg);
    assign min_tens  = div10({3'd0, min_reg});
    assign hour_tens = div10({4'd0, hour_reg});
    assign year_tens = div10({2'd0, year_reg});

    always_comb begin
        digit = 4'd0;
        unique case (entry.src)
            SRC_MIN_T: digit = {1'b0, min_tens[2:0]};
            SRC_MIN_O: digit = mod10({3'd0, min_reg});
            SRC_HR_T:  digit = {2'b00, hour_tens[1:0]};
            SRC_HR_O:  digit = mod10({4'd0, hour_reg});
            SRC_DAY_H: digit = {1'b0, div100(day_reg)};
            SRC_DAY_T: digit = mod10({3'd0, day_tens});
            SRC_DAY_O: digit = mod10(day_reg);
            SRC_YR_T:  digit = mod10({3'd0, year_tens});
            SRC_YR_O:  digit = mod10({2'd0, year_reg});
            SRC_LEAP:  digit = {3'd0, flag_reg[0]};
            SRC_DST_N: digit = {3'd0, flag_reg[1]};
            SRC_DST_B: digit = {3'd0, flag_reg[2]};
            default:   digit = 4'd0;
        endcase
    end

    // symbol and its duration
    always_comb begin
        unique case (entry.src)
            SRC_MARK: sym = SYM_MARK;
            SRC_ONE:  sym = SYM_ONE;
            SRC_ZERO: sym = SYM_ZERO;
            default:  sym = digit[entry.pos] ? SYM_ONE : SYM_ZERO;
        endcase
        unique case (sym)
            SYM_MARK: ms = MS_MARK;
            SYM_ONE:  ms = MS_ONE;
            default:  ms = MS_ZERO;
        endcase
    end

    // clock advance and stop conditions
    assign min_inc    = {1'b0, min_reg} + 7'd1;
    assign hour_inc   = {1'b0, hour_reg} + 6'd1;
    assign frames_inc = frames_reg + 8'd1;

    always_comb begin
        active_next = active_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        flag_next   = flag_reg;
        frames_next = frames_reg;
        last        = 1'b0;
        if (in_beat && (s_tuser == ACT_LOAD)) begin
            year_next   = s_tdata[6:0];
            day_next    = s_tdata[15:7];
            hour_next   = s_tdata[20:16];
            min_next    = s_tdata[26:21];
            sec_next    = s_tdata[32:27];
            flag_next   = s_tdata[35:33];
            frames_next = 8'd0;
            active_next = 1'b1;
        end else if (tick_emit) begin
            if (sec_reg >= SEC_LAST) begin
                sec_next    = 6'd0;
                frames_next = frames_inc;
                if (frames_inc >= max_frames_reg) begin
                    last = 1'b1;
                end else if (min_inc >= MIN_PER_HR) begin
                    min_next  = 6'd0;
                    hour_next = hour_inc[4:0];
                    if (hour_inc >= HR_PER_DAY) begin
                        last = 1'b1;
                    end
                end else begin
                    min_next = min_inc[5:0];
                end
            end else begin
                sec_next = sec_reg + 6'd1;
            end
            if (last) begin
                active_next = 1'b0;
            end
        end
    end

    // output register: filled by a tick, drained by the downstream beat
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (tick_emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {4'd0, ms, sym};
            out_last_next  = last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            day_reg       <= 9'd1;
            year_reg      <= 7'd0;
            flag_reg      <= 3'd0;
            frames_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            year_reg      <= year_next;
            flag_reg      <= flag_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
